FILE: rtl/byte_pipe_fifo_engine_assert.svh
// Assertion macros for the byte pipe FIFO engine.
`ifndef BYTE_PIPE_FIFO_ENGINE_ASSERT_SVH
`define BYTE_PIPE_FIFO_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

`define BPFE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("byte pipe check failed");

`define BPFE_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("byte pipe reset check failed");

`else

`define BPFE_ASSERT(lbl, clk, rstn, prop)

`define BPFE_ASSERT_NORST(lbl, clk, prop)

`endif

`endif

FILE: rtl/bpfe_pkg.sv
// Shared types, constants and helpers for the byte pipe FIFO engine.
`default_nettype none

package bpfe_pkg;

    localparam int CAPACITY  = 65536;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int LEN_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int FIELD_W   = 17;
    localparam int LIMIT_W   = 17;
    localparam int CMD_W     = 3;
    localparam int STAT_W    = 3;
    localparam int S_USED_W  = LEN_W + BYTE_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;
    localparam int M_USED_W  = 4 * FIELD_W + BYTE_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_USED_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

    typedef enum logic [CMD_W-1:0] {
        CMD_WR_REQ   = 3'd0,
        CMD_WR_BYTE  = 3'd1,
        CMD_RD_REQ   = 3'd2,
        CMD_RD_BYTE  = 3'd3,
        CMD_CLOSE_RD = 3'd4,
        CMD_CLOSE_WR = 3'd5
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 3'd0,
        STAT_BLOCK = 3'd1,
        STAT_EOF   = 3'd2,
        STAT_PIPE  = 3'd3,
        STAT_PROTO = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PK_NONE  = 2'd0,
        PK_WRITE = 2'd1,
        PK_READ  = 2'd2
    } pend_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } fsm_t;

    typedef struct packed {
        logic load;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_status_t;

    function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[FIELD_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] next_pos(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bpfe_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bpfe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bpfe_ctrl.sv
// Control state machine: capture a beat, then resolve it once the result slot is free.
`default_nettype none

module bpfe_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire bpfe_pkg::dp_status_t  dp_sts,
    output bpfe_pkg::ctrl_cmd_t        cmd
);

    bpfe_pkg::fsm_t state_reg;
    bpfe_pkg::fsm_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bpfe_pkg::FSM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpfe_pkg::FSM_IDLE: begin
                if (s_tvalid) begin
                    state_next = bpfe_pkg::FSM_EXEC;
                end
            end
            bpfe_pkg::FSM_EXEC: begin
                if (!dp_sts.out_stall) begin
                    state_next = bpfe_pkg::FSM_IDLE;
                end
            end
            default: begin
                state_next = bpfe_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            bpfe_pkg::FSM_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            bpfe_pkg::FSM_EXEC: begin
                cmd.commit = !dp_sts.out_stall;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/bpfe_datapath.sv
// Datapath: ring store, pointers, fill count, open flags, pending transfer and result register.
`default_nettype none

module bpfe_datapath (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire bpfe_pkg::ctrl_cmd_t              cmd,
    output bpfe_pkg::dp_status_t                  dp_sts,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bpfe_pkg::LIMIT_W-1:0]     cfg_wr_data,
    input  wire logic [bpfe_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [bpfe_pkg::CMD_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [bpfe_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [bpfe_pkg::STAT_W-1:0]      m_tuser,
    output logic                                  m_tlast
);

    localparam logic [bpfe_pkg::CNT_W-1:0] CAP_CNT = bpfe_pkg::CNT_W'(bpfe_pkg::CAPACITY);

    // captured beat
    bpfe_pkg::cmd_t                  cmd_in_reg;
    logic [bpfe_pkg::LEN_W-1:0]      len_reg;
    logic [bpfe_pkg::BYTE_W-1:0]     byte_reg;

    // pipe state
    logic [bpfe_pkg::ADDR_W-1:0]     wpos_reg, wpos_next;
    logic [bpfe_pkg::ADDR_W-1:0]     rpos_reg, rpos_next;
    logic [bpfe_pkg::CNT_W-1:0]      fill_reg, fill_next;
    logic                            rd_open_reg, rd_open_next;
    logic                            wr_open_reg, wr_open_next;
    bpfe_pkg::pend_t                 pend_kind_reg, pend_kind_next;
    logic [bpfe_pkg::CNT_W-1:0]      pend_left_reg, pend_left_next;
    logic [bpfe_pkg::LIMIT_W-1:0]    limit_reg;

    // result register
    logic                            m_tvalid_reg;
    bpfe_pkg::status_t               out_status_reg;
    logic [bpfe_pkg::FIELD_W-1:0]    out_grant_reg;
    logic [bpfe_pkg::FIELD_W-1:0]    out_needed_reg;
    logic [bpfe_pkg::BYTE_W-1:0]     out_rdata_reg;
    logic                            out_last_reg;
    logic [bpfe_pkg::FIELD_W-1:0]    out_buffered_reg;
    logic [bpfe_pkg::FIELD_W-1:0]    out_space_reg;

    bpfe_pkg::status_t               res_status;
    logic [bpfe_pkg::CNT_W-1:0]      res_grant;
    logic [bpfe_pkg::FIELD_W-1:0]    res_needed;
    logic [bpfe_pkg::BYTE_W-1:0]     res_rdata;
    logic                            res_last;
    logic                            wr_fire;

    logic [bpfe_pkg::BYTE_W-1:0]     ram_rdata;
    logic [bpfe_pkg::CNT_W-1:0]      space;
    logic                            len_zero;
    logic                            len_gt_limit;
    logic                            space_ge_len;
    logic [bpfe_pkg::CNT_W-1:0]      grant_wr;
    logic [bpfe_pkg::CNT_W-1:0]      grant_rd;
    logic [bpfe_pkg::FIELD_W-1:0]    need_wr;

    bpfe_ram #(
        .WIDTH (bpfe_pkg::BYTE_W),
        .DEPTH (bpfe_pkg::CAPACITY)
    ) u_ring (
        .clk   (aclk),
        .we    (wr_fire & cmd.commit),
        .waddr (wpos_reg),
        .wdata (byte_reg),
        .re    (cmd.load),
        .raddr (rpos_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_in_reg <= bpfe_pkg::cmd_t'(s_tuser);
            len_reg    <= s_tdata[bpfe_pkg::LEN_W-1:0];
            byte_reg   <= s_tdata[bpfe_pkg::S_USED_W-1:bpfe_pkg::LEN_W];
        end
    end

    assign space        = CAP_CNT - fill_reg;
    assign len_zero     = (len_reg == '0);
    assign len_gt_limit = (len_reg > 32'(limit_reg));
    assign space_ge_len = (32'(space) >= len_reg);
    assign grant_wr     = (len_reg < 32'(space)) ? bpfe_pkg::CNT_W'(len_reg) : space;
    assign grant_rd     = (len_reg < 32'(fill_reg)) ? bpfe_pkg::CNT_W'(len_reg) : fill_reg;
    assign need_wr      = len_gt_limit ? bpfe_pkg::FIELD_W'(1) : len_reg[bpfe_pkg::FIELD_W-1:0];

    always_comb begin
        res_status     = bpfe_pkg::STAT_OK;
        res_grant      = '0;
        res_needed     = '0;
        res_rdata      = '0;
        res_last       = 1'b0;
        wr_fire        = 1'b0;
        wpos_next      = wpos_reg;
        rpos_next      = rpos_reg;
        fill_next      = fill_reg;
        rd_open_next   = rd_open_reg;
        wr_open_next   = wr_open_reg;
        pend_kind_next = pend_kind_reg;
        pend_left_next = pend_left_reg;
        case (cmd_in_reg)
            bpfe_pkg::CMD_WR_REQ: begin
                if (pend_kind_reg != bpfe_pkg::PK_NONE) begin
                    res_status = bpfe_pkg::STAT_PROTO;
                end else if (!len_zero) begin
                    if (!rd_open_reg) begin
                        res_status = bpfe_pkg::STAT_PIPE;
                    end else if (space != '0 && (len_gt_limit || space_ge_len)) begin
                        res_grant      = grant_wr;
                        pend_kind_next = bpfe_pkg::PK_WRITE;
                        pend_left_next = grant_wr;
                    end else begin
                        res_status = bpfe_pkg::STAT_BLOCK;
                        res_needed = need_wr;
                    end
                end
            end
            bpfe_pkg::CMD_WR_BYTE: begin
                if (pend_kind_reg != bpfe_pkg::PK_WRITE || pend_left_reg == '0) begin
                    res_status = bpfe_pkg::STAT_PROTO;
                end else begin
                    wr_fire        = 1'b1;
                    wpos_next      = bpfe_pkg::next_pos(wpos_reg);
                    fill_next      = fill_reg + 1'b1;
                    pend_left_next = pend_left_reg - 1'b1;
                    if (pend_left_reg == bpfe_pkg::CNT_W'(1)) begin
                        res_last       = 1'b1;
                        pend_kind_next = bpfe_pkg::PK_NONE;
                    end
                end
            end
            bpfe_pkg::CMD_RD_REQ: begin
                if (pend_kind_reg != bpfe_pkg::PK_NONE) begin
                    res_status = bpfe_pkg::STAT_PROTO;
                end else if (!len_zero) begin
                    if (fill_reg != '0) begin
                        res_grant      = grant_rd;
                        pend_kind_next = bpfe_pkg::PK_READ;
                        pend_left_next = grant_rd;
                    end else if (!wr_open_reg) begin
                        res_status = bpfe_pkg::STAT_EOF;
                    end else begin
                        res_status = bpfe_pkg::STAT_BLOCK;
                    end
                end
            end
            bpfe_pkg::CMD_RD_BYTE: begin
                if (pend_kind_reg != bpfe_pkg::PK_READ || pend_left_reg == '0 ||
                    fill_reg == '0) begin
                    res_status = bpfe_pkg::STAT_PROTO;
                end else begin
                    res_rdata      = ram_rdata;
                    rpos_next      = bpfe_pkg::next_pos(rpos_reg);
                    fill_next      = fill_reg - 1'b1;
                    pend_left_next = pend_left_reg - 1'b1;
                    if (pend_left_reg == bpfe_pkg::CNT_W'(1)) begin
                        res_last       = 1'b1;
                        pend_kind_next = bpfe_pkg::PK_NONE;
                    end
                end
            end
            bpfe_pkg::CMD_CLOSE_RD: begin
                rd_open_next = 1'b0;
            end
            bpfe_pkg::CMD_CLOSE_WR: begin
                wr_open_next = 1'b0;
            end
            default: begin
                res_status = bpfe_pkg::STAT_PROTO;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg      <= '0;
            rpos_reg      <= '0;
            fill_reg      <= '0;
            rd_open_reg   <= 1'b1;
            wr_open_reg   <= 1'b1;
            pend_kind_reg <= bpfe_pkg::PK_NONE;
            pend_left_reg <= '0;
        end else if (cmd.commit) begin
            wpos_reg      <= wpos_next;
            rpos_reg      <= rpos_next;
            fill_reg      <= fill_next;
            rd_open_reg   <= rd_open_next;
            wr_open_reg   <= wr_open_next;
            pend_kind_reg <= pend_kind_next;
            pend_left_reg <= pend_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= bpfe_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_status_reg   <= res_status;
            out_grant_reg    <= bpfe_pkg::to_field(res_grant);
            out_needed_reg   <= res_needed;
            out_rdata_reg    <= res_rdata;
            out_last_reg     <= res_last;
            out_buffered_reg <= bpfe_pkg::to_field(fill_next);
            out_space_reg    <= bpfe_pkg::to_field(CAP_CNT - fill_next);
        end
    end

    assign dp_sts.out_stall = m_tvalid_reg & ~m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{bpfe_pkg::M_PAD_W{1'b0}}, out_space_reg, out_buffered_reg,
                       out_rdata_reg, out_needed_reg, out_grant_reg};

`include "byte_pipe_fifo_engine_assert.svh"

    `BPFE_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= CAP_CNT)
    `BPFE_ASSERT(a_idle_no_left, aclk, aresetn,
        (pend_kind_reg == bpfe_pkg::PK_NONE) |-> (pend_left_reg == '0))
    `BPFE_ASSERT(a_read_covered, aclk, aresetn,
        (pend_kind_reg == bpfe_pkg::PK_READ) |-> (pend_left_reg <= fill_reg))
    `BPFE_ASSERT(a_write_fits, aclk, aresetn,
        (pend_kind_reg == bpfe_pkg::PK_WRITE) |-> (pend_left_reg <= space))
    `BPFE_ASSERT_NORST(a_reset_empty, aclk, !aresetn |=> !m_tvalid_reg)

endmodule

`default_nettype wire

FILE: rtl/byte_pipe_fifo_engine.sv
// Top level of the byte pipe FIFO engine.
`default_nettype none

// Byte pipe over a 64 KiB ring store. Each input beat is a write request, write
// byte, read request, read byte or close command and yields exactly one result
// beat. A beat is handled in two steps: the first captures it and starts the ring-store
// read at the read pointer, the second resolves it, updates pointers and counters, and
// loads the result register; the second step stretches while that register still
// holds a result not taken. The store needs no clearing pass after reset, since
// only buffered bytes are ever read. atomic_write_limit is written through
// cfg_wr_en/cfg_wr_data and should only change while the engine is idle.

module byte_pipe_fifo_engine (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bpfe_pkg::LIMIT_W-1:0]     cfg_wr_data,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // request_length[31:0], data_byte[39:32]
    input  wire logic [bpfe_pkg::S_TDATA_W-1:0]   s_tdata,
    // command[2:0]
    input  wire logic [bpfe_pkg::CMD_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // granted_length[16:0], wait_space[33:17], read_data[41:34],
    // bytes_buffered[58:42], space_free[75:59], zero[79:76]
    output logic      [bpfe_pkg::M_TDATA_W-1:0]   m_tdata,
    // status[2:0]
    output logic      [bpfe_pkg::STAT_W-1:0]      m_tuser,
    // last_byte
    output logic                                  m_tlast
);

    bpfe_pkg::ctrl_cmd_t  ctrl_cmd;
    bpfe_pkg::dp_status_t dp_sts;

    bpfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_sts   (dp_sts),
        .cmd      (ctrl_cmd)
    );

    bpfe_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (ctrl_cmd),
        .dp_sts      (dp_sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire
